// ----- sv/hmbp_pkg.sv -----
// ----------------------------------------------------------------------------
// hmbp_pkg
// Shared types and constants of the hit merge block: field widths, the
// operation codes, the command word passed from front to back and the
// state type of the back end.
// ----------------------------------------------------------------------------
package hmbp_pkg;

	localparam int TABLE_DEPTH_DEF = 64;
	localparam int COORD_BITS_DEF  = 8;

	localparam int VIEW_W     = 2;
	localparam int PCOORD_W   = 8;
	localparam int HCHARGE_W  = 16;
	localparam int CHARGE_W   = 20;
	localparam logic [CHARGE_W-1:0] CHARGE_MAX = {CHARGE_W{1'b1}};

	localparam int QUEUE_DEPTH = 2;

	typedef enum logic {
		OP_LOAD   = 1'b0,
		OP_FINISH = 1'b1
	} op_t;

	typedef struct packed {
		op_t                  op;
		logic [VIEW_W-1:0]    view;
		logic [PCOORD_W-1:0]  x;
		logic [PCOORD_W-1:0]  y;
		logic [PCOORD_W-1:0]  z;
		logic [HCHARGE_W-1:0] charge;
		logic                 crosstalk;
	} cmd_t;

	typedef enum logic [1:0] {
		ST_LOOK,
		ST_UPDATE,
		ST_DRAIN
	} back_state_t;

endpackage

// ----- sv/hit_merge_by_position.sv -----
// ----------------------------------------------------------------------------
// hit_merge_by_position
// Merges the hits of one event by view and position and streams the merged
// hits out when the event is finished.
// ----------------------------------------------------------------------------
// A request word either loads one hit or finishes the event. Words enter a
// two-word queue and are worked off by the merge table one at a time. A hit
// that opens a new entry is written straight into the entry memory; a hit
// that matches a stored entry has its charge read and then written back in
// the update state, through the single port of the entry memory. The match
// itself is a parallel compare against all stored positions. A finish walks
// the entry memory one entry per cycle up to the last entry with nonzero
// charge, with steps to start the walk, wait out the read latency and close
// the event, and a slow consumer stretches that walk. An event with no
// charged entry yields a single word with out_valid low and out_last high.
// The table needs no clearing pass after reset.
module hit_merge_by_position #(
	parameter int TABLE_DEPTH = hmbp_pkg::TABLE_DEPTH_DEF,
	parameter int COORD_BITS  = hmbp_pkg::COORD_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic                           operation,
	input  logic [hmbp_pkg::VIEW_W-1:0]    hit_view,
	input  logic [hmbp_pkg::PCOORD_W-1:0]  hit_x,
	input  logic [hmbp_pkg::PCOORD_W-1:0]  hit_y,
	input  logic [hmbp_pkg::PCOORD_W-1:0]  hit_z,
	input  logic [hmbp_pkg::HCHARGE_W-1:0] hit_charge,
	input  logic                           hit_crosstalk,
	output logic                           rsp_valid,
	input  logic                           rsp_ready,
	output logic                           out_valid,
	output logic [hmbp_pkg::VIEW_W-1:0]    out_view,
	output logic [hmbp_pkg::PCOORD_W-1:0]  out_x,
	output logic [hmbp_pkg::PCOORD_W-1:0]  out_y,
	output logic [hmbp_pkg::PCOORD_W-1:0]  out_z,
	output logic [hmbp_pkg::CHARGE_W-1:0]  out_charge,
	output logic                           out_crosstalk,
	output logic                           out_overflow,
	output logic                           out_last
);
	import hmbp_pkg::*;

	logic head_valid;
	cmd_t head;
	logic pop;

	hmbp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.req_valid     (req_valid),
		.req_ready     (req_ready),
		.operation     (operation),
		.hit_view      (hit_view),
		.hit_x         (hit_x),
		.hit_y         (hit_y),
		.hit_z         (hit_z),
		.hit_charge    (hit_charge),
		.hit_crosstalk (hit_crosstalk),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop)
	);

	hmbp_back #(
		.TABLE_DEPTH (TABLE_DEPTH),
		.COORD_BITS  (COORD_BITS)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head_valid    (head_valid),
		.head          (head),
		.pop           (pop),
		.rsp_valid     (rsp_valid),
		.rsp_ready     (rsp_ready),
		.out_valid     (out_valid),
		.out_view      (out_view),
		.out_x         (out_x),
		.out_y         (out_y),
		.out_z         (out_z),
		.out_charge    (out_charge),
		.out_crosstalk (out_crosstalk),
		.out_overflow  (out_overflow),
		.out_last      (out_last)
	);

endmodule

// ----- sv/hmbp_front.sv -----
// ----------------------------------------------------------------------------
// hmbp_front
// Accepts request words, tags each as a hit load or an event finish and
// holds them in a short queue until the back end takes them.
// ----------------------------------------------------------------------------
module hmbp_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	output logic                           req_ready,
	input  logic                           operation,
	input  logic [hmbp_pkg::VIEW_W-1:0]    hit_view,
	input  logic [hmbp_pkg::PCOORD_W-1:0]  hit_x,
	input  logic [hmbp_pkg::PCOORD_W-1:0]  hit_y,
	input  logic [hmbp_pkg::PCOORD_W-1:0]  hit_z,
	input  logic [hmbp_pkg::HCHARGE_W-1:0] hit_charge,
	input  logic                           hit_crosstalk,
	output logic                           head_valid,
	output hmbp_pkg::cmd_t                 head,
	input  logic                           pop
);
	import hmbp_pkg::*;

	localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCW = $clog2(QUEUE_DEPTH + 1);

	cmd_t           queue_q [QUEUE_DEPTH];
	logic [QPW-1:0] wr_ptr_q;
	logic [QPW-1:0] rd_ptr_q;
	logic [QCW-1:0] fill_q;
	cmd_t           cmd;
	logic           push;

	always_comb begin
		cmd.op        = operation ? OP_FINISH : OP_LOAD;
		cmd.view      = hit_view;
		cmd.x         = hit_x;
		cmd.y         = hit_y;
		cmd.z         = hit_z;
		cmd.charge    = hit_charge;
		cmd.crosstalk = hit_crosstalk;
	end

	assign req_ready  = (fill_q < QCW'(QUEUE_DEPTH));
	assign push       = req_valid && req_ready;
	assign head_valid = (fill_q != '0);
	assign head       = queue_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			queue_q[wr_ptr_q] <= cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

endmodule

// ----- sv/hmbp_back.sv -----
// ----------------------------------------------------------------------------
// hmbp_back
// Merge table: parallel key match against the stored positions, charge
// update through a single-port entry memory, and the finish drain that
// streams the nonzero entries into the output register.
// ----------------------------------------------------------------------------
module hmbp_back #(
	parameter int TABLE_DEPTH = hmbp_pkg::TABLE_DEPTH_DEF,
	parameter int COORD_BITS  = hmbp_pkg::COORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  hmbp_pkg::cmd_t                head,
	output logic                          pop,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output logic                          out_valid,
	output logic [hmbp_pkg::VIEW_W-1:0]   out_view,
	output logic [hmbp_pkg::PCOORD_W-1:0] out_x,
	output logic [hmbp_pkg::PCOORD_W-1:0] out_y,
	output logic [hmbp_pkg::PCOORD_W-1:0] out_z,
	output logic [hmbp_pkg::CHARGE_W-1:0] out_charge,
	output logic                          out_crosstalk,
	output logic                          out_overflow,
	output logic                          out_last
);
	import hmbp_pkg::*;

	localparam int KW = VIEW_W + 3 * COORD_BITS;
	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = $clog2(TABLE_DEPTH + 1);
	localparam int MW = KW + CHARGE_W + 1;

	back_state_t state_q, state_d;

	logic [KW-1:0]          key_q [TABLE_DEPTH];
	logic [MW-1:0]          entry_mem [TABLE_DEPTH];
	logic [MW-1:0]          rd_word_q;

	logic [CW-1:0]          count_q;
	logic                   overflow_q;
	logic                   any_nz_q;
	logic [IW-1:0]          last_nz_q;
	logic [IW-1:0]          upd_idx_q;
	logic [HCHARGE_W-1:0]   upd_charge_q;
	logic                   upd_xt_q;
	logic [IW-1:0]          drn_idx_q;
	logic                   drn_issued_q;
	logic                   drn_vld_s1;
	logic [IW-1:0]          drn_idx_s1;

	logic                   res_valid_q;
	logic [VIEW_W-1:0]      res_view_q;
	logic [PCOORD_W-1:0]    res_x_q;
	logic [PCOORD_W-1:0]    res_y_q;
	logic [PCOORD_W-1:0]    res_z_q;
	logic [CHARGE_W-1:0]    res_charge_q;
	logic                   res_xt_q;
	logic                   res_ovf_q;
	logic                   res_last_q;
	logic                   rsp_valid_q;

	logic [KW-1:0]          head_key;
	logic [TABLE_DEPTH-1:0] match;
	logic [IW-1:0]          match_idx;
	logic                   hit;
	logic                   full;
	logic                   out_free;

	logic [KW-1:0]          rd_key;
	logic [CHARGE_W-1:0]    rd_charge;
	logic                   rd_xt;
	logic [CHARGE_W:0]      upd_sum;
	logic [CHARGE_W-1:0]    upd_charge_sat;

	logic                   mem_rd;
	logic [IW-1:0]          rd_addr;
	logic                   mem_we;
	logic [IW-1:0]          wr_addr;
	logic [MW-1:0]          wr_word;
	logic                   new_entry;
	logic                   upd_load;
	logic                   upd_we;
	logic                   set_ovf;
	logic                   drn_start;
	logic                   drn_move;
	logic                   drn_done;
	logic                   emit_empty;
	logic                   emit_entry;
	logic                   clear_evt;

	assign head_key = {head.view, COORD_BITS'(head.x), COORD_BITS'(head.y),
		COORD_BITS'(head.z)};

	// Keys below the fill count are unique, so at most one entry matches.
	always_comb begin
		match     = '0;
		match_idx = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			match[i] = (CW'(i) < count_q) && (key_q[i] == head_key);
			if (match[i]) begin
				match_idx = match_idx | IW'(i);
			end
		end
	end

	assign hit      = |match;
	assign full     = (count_q == CW'(TABLE_DEPTH));
	assign out_free = !rsp_valid_q || rsp_ready;

	assign rd_key    = rd_word_q[MW-1 -: KW];
	assign rd_charge = rd_word_q[CHARGE_W:1];
	assign rd_xt     = rd_word_q[0];

	assign upd_sum        = {1'b0, rd_charge} + (CHARGE_W + 1)'(upd_charge_q);
	assign upd_charge_sat = upd_sum[CHARGE_W] ? CHARGE_MAX : upd_sum[CHARGE_W-1:0];

	// Zero-charge entries are dropped without waiting for the output register.
	assign drn_move = drn_vld_s1 && (out_free || (rd_charge == '0));

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOOK: begin
				if (head_valid && (head.op == OP_LOAD) && hit) begin
					state_d = ST_UPDATE;
				end else if (head_valid && (head.op == OP_FINISH) && any_nz_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_UPDATE: begin
				state_d = ST_LOOK;
			end
			ST_DRAIN: begin
				if (drn_issued_q && !drn_vld_s1) begin
					state_d = ST_LOOK;
				end
			end
			default: begin
				state_d = ST_LOOK;
			end
		endcase
	end

	always_comb begin
		pop        = 1'b0;
		mem_rd     = 1'b0;
		rd_addr    = match_idx;
		mem_we     = 1'b0;
		wr_addr    = count_q[IW-1:0];
		wr_word    = {head_key, CHARGE_W'(head.charge), head.crosstalk};
		new_entry  = 1'b0;
		upd_load   = 1'b0;
		upd_we     = 1'b0;
		set_ovf    = 1'b0;
		drn_start  = 1'b0;
		drn_done   = 1'b0;
		emit_empty = 1'b0;
		emit_entry = 1'b0;
		clear_evt  = 1'b0;
		unique case (state_q)
			ST_LOOK: begin
				if (head_valid) begin
					if (head.op == OP_LOAD) begin
						pop = 1'b1;
						if (hit) begin
							mem_rd   = 1'b1;
							upd_load = 1'b1;
						end else if (!full) begin
							mem_we    = 1'b1;
							new_entry = 1'b1;
						end else begin
							set_ovf = 1'b1;
						end
					end else if (any_nz_q) begin
						drn_start = 1'b1;
					end else if (out_free) begin
						emit_empty = 1'b1;
						clear_evt  = 1'b1;
						pop        = 1'b1;
					end
				end
			end
			ST_UPDATE: begin
				mem_we  = 1'b1;
				upd_we  = 1'b1;
				wr_addr = upd_idx_q;
				wr_word = {rd_key, upd_charge_sat, rd_xt & upd_xt_q};
			end
			ST_DRAIN: begin
				rd_addr    = drn_idx_q;
				mem_rd     = !drn_issued_q && (!drn_vld_s1 || drn_move);
				emit_entry = drn_move && (rd_charge != '0);
				if (drn_issued_q && !drn_vld_s1) begin
					drn_done  = 1'b1;
					clear_evt = 1'b1;
					pop       = 1'b1;
				end
			end
			default: begin
				pop = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			entry_mem[wr_addr] <= wr_word;
		end
		if (mem_rd) begin
			rd_word_q <= entry_mem[rd_addr];
		end
		if (new_entry) begin
			key_q[count_q[IW-1:0]] <= head_key;
		end
		if (upd_load) begin
			upd_idx_q    <= match_idx;
			upd_charge_q <= head.charge;
			upd_xt_q     <= head.crosstalk;
		end
		if (mem_rd && (state_q == ST_DRAIN)) begin
			drn_idx_s1 <= drn_idx_q;
		end
		if (emit_empty) begin
			res_valid_q  <= 1'b0;
			res_view_q   <= '0;
			res_x_q      <= '0;
			res_y_q      <= '0;
			res_z_q      <= '0;
			res_charge_q <= '0;
			res_xt_q     <= 1'b0;
			res_ovf_q    <= overflow_q;
			res_last_q   <= 1'b1;
		end else if (emit_entry) begin
			res_valid_q  <= 1'b1;
			res_view_q   <= rd_key[KW-1 -: VIEW_W];
			res_x_q      <= PCOORD_W'(rd_key[3*COORD_BITS-1 -: COORD_BITS]);
			res_y_q      <= PCOORD_W'(rd_key[2*COORD_BITS-1 -: COORD_BITS]);
			res_z_q      <= PCOORD_W'(rd_key[COORD_BITS-1:0]);
			res_charge_q <= rd_charge;
			res_xt_q     <= rd_xt;
			res_ovf_q    <= overflow_q;
			res_last_q   <= (drn_idx_s1 == last_nz_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_LOOK;
			count_q      <= '0;
			overflow_q   <= 1'b0;
			any_nz_q     <= 1'b0;
			last_nz_q    <= '0;
			drn_idx_q    <= '0;
			drn_issued_q <= 1'b0;
			drn_vld_s1   <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;

			if (clear_evt) begin
				count_q    <= '0;
				overflow_q <= 1'b0;
			end else begin
				if (new_entry) begin
					count_q <= count_q + 1'b1;
				end
				if (set_ovf) begin
					overflow_q <= 1'b1;
				end
			end

			// Charges never decrease, so the highest nonzero index only grows.
			if (clear_evt) begin
				any_nz_q <= 1'b0;
			end else if (new_entry && (head.charge != '0)) begin
				any_nz_q  <= 1'b1;
				last_nz_q <= count_q[IW-1:0];
			end else if (upd_we && (upd_charge_sat != '0)
					&& (!any_nz_q || (upd_idx_q > last_nz_q))) begin
				any_nz_q  <= 1'b1;
				last_nz_q <= upd_idx_q;
			end

			if (drn_start) begin
				drn_idx_q    <= '0;
				drn_issued_q <= 1'b0;
			end else if (mem_rd && (state_q == ST_DRAIN)) begin
				drn_idx_q <= drn_idx_q + 1'b1;
				if (drn_idx_q == last_nz_q) begin
					drn_issued_q <= 1'b1;
				end
			end

			if (mem_rd && (state_q == ST_DRAIN)) begin
				drn_vld_s1 <= 1'b1;
			end else if (drn_move) begin
				drn_vld_s1 <= 1'b0;
			end

			if (emit_empty || emit_entry) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid     = rsp_valid_q;
	assign out_valid     = res_valid_q;
	assign out_view      = res_view_q;
	assign out_x         = res_x_q;
	assign out_y         = res_y_q;
	assign out_z         = res_z_q;
	assign out_charge    = res_charge_q;
	assign out_crosstalk = res_xt_q;
	assign out_overflow  = res_ovf_q;
	assign out_last      = res_last_q;

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_DEPTH))
		else $error("entry count beyond table depth");

	a_unique_match: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOOK) && head_valid |-> $onehot0(match))
		else $error("more than one table entry matches a hit");

	a_last_in_table: assert property (@(posedge clk) disable iff (!arst_n)
		any_nz_q |-> (CW'(last_nz_q) < count_q))
		else $error("last nonzero entry lies beyond the fill count");

	a_drain_clears: assert property (@(posedge clk) disable iff (!arst_n)
		drn_done |=> (count_q == '0) && !any_nz_q && !overflow_q)
		else $error("table not cleared after the finish drain");

	a_no_emit_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_entry || emit_empty) |-> (!rsp_valid_q || rsp_ready))
		else $error("result loaded over a word not yet taken");

endmodule
